// File: rtl/uvs_pkg.sv
// Shared types, codes and constant tables for the UV sphere cell generator.
// Depends on nothing; every RTL file refers to it by scoped names.
package uvs_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Triangle patterns of a cell.
  localparam logic [1:0] TRI_FIRST = 2'd0;
  localparam logic [1:0] TRI_LAST  = 2'd1;
  localparam logic [1:0] TRI_MID   = 2'd2;

  // Register selects: the value of paddr[2] (byte addresses 0 and 4).
  localparam logic REG_STACK_COUNT = 1'b0;
  localparam logic REG_SLICE_COUNT = 1'b1;

  // Four angle lanes: theta0, theta1, phi0, phi1.
  localparam int LANES = 4;

  // Phase divider: 32 quotient bits, four per stage.
  localparam int DIV_STAGES = 8;
  localparam int DIV_STEPS  = 4;

  // Horner series of seven steps, three stages each.
  localparam int SERIES_STEPS = 7;

  // Stage map of the pipeline.
  localparam int ST_A   = DIV_STAGES + 1;
  localparam int ST_B   = ST_A + 1;
  localparam int ST_H0  = ST_B + 1;
  localparam int ST_E   = ST_H0 + 3 * SERIES_STEPS;
  localparam int ST_F   = ST_E + 1;
  localparam int NSTG   = ST_F + 1;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef struct packed {
    logic        err;
    logic [15:0] base;
    logic [1:0]  tri_kind;
  } side_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic        swap;
    logic [1:0]  quad;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [29:0] vs;
    logic [29:0] vc;
    logic [61:0] ms;
    logic [61:0] mc;
  } ser_t;

  typedef struct packed {
    logic [30:0] sn_mag;
    logic        sn_neg;
    logic [30:0] cs_mag;
    logic        cs_neg;
  } trig_t;

  // Sine series divisors (2n)(2n+1), for n from 7 down to 1.
  function automatic logic [7:0] sin_div(input logic [2:0] j);
    case (j)
      3'd0:    sin_div = 8'd210;
      3'd1:    sin_div = 8'd156;
      3'd2:    sin_div = 8'd110;
      3'd3:    sin_div = 8'd72;
      3'd4:    sin_div = 8'd42;
      3'd5:    sin_div = 8'd20;
      default: sin_div = 8'd6;
    endcase
  endfunction

  // Reciprocals floor(2^sh / d) of the sine divisors.
  function automatic logic [31:0] sin_recip(input logic [2:0] j);
    case (j)
      3'd0:    sin_recip = 32'd2617884828;
      3'd1:    sin_recip = 32'd3524075730;
      3'd2:    sin_recip = 32'd2498890063;
      3'd3:    sin_recip = 32'd3817748707;
      3'd4:    sin_recip = 32'd3272356035;
      3'd5:    sin_recip = 32'd3435973836;
      default: sin_recip = 32'd2863311530;
    endcase
  endfunction

  function automatic logic [5:0] sin_shift(input logic [2:0] j);
    case (j)
      3'd0:    sin_shift = 6'd39;
      3'd1:    sin_shift = 6'd39;
      3'd2:    sin_shift = 6'd38;
      3'd3:    sin_shift = 6'd38;
      3'd4:    sin_shift = 6'd37;
      3'd5:    sin_shift = 6'd36;
      default: sin_shift = 6'd34;
    endcase
  endfunction

  // Cosine series divisors (2n-1)(2n), for n from 7 down to 1.
  function automatic logic [7:0] cos_div(input logic [2:0] j);
    case (j)
      3'd0:    cos_div = 8'd182;
      3'd1:    cos_div = 8'd132;
      3'd2:    cos_div = 8'd90;
      3'd3:    cos_div = 8'd56;
      3'd4:    cos_div = 8'd30;
      3'd5:    cos_div = 8'd12;
      default: cos_div = 8'd2;
    endcase
  endfunction

  function automatic logic [31:0] cos_recip(input logic [2:0] j);
    case (j)
      3'd0:    cos_recip = 32'd3020636340;
      3'd1:    cos_recip = 32'd4164816771;
      3'd2:    cos_recip = 32'd3054198966;
      3'd3:    cos_recip = 32'd2454267026;
      3'd4:    cos_recip = 32'd2290649224;
      3'd5:    cos_recip = 32'd2863311530;
      default: cos_recip = 32'd2147483648;
    endcase
  endfunction

  function automatic logic [5:0] cos_shift(input logic [2:0] j);
    case (j)
      3'd0:    cos_shift = 6'd39;
      3'd1:    cos_shift = 6'd39;
      3'd2:    cos_shift = 6'd38;
      3'd3:    cos_shift = 6'd37;
      3'd4:    cos_shift = 6'd36;
      3'd5:    cos_shift = 6'd35;
      default: cos_shift = 6'd32;
    endcase
  endfunction

endpackage

// File: rtl/uv_sphere_cell_generator_top.sv
// UV sphere cell generator: phase divider, sine/cosine series pipeline and
// result sequencer. Depends on uvs_pkg.
//
// Usage: an input item (stack_index, slice_index) names one sphere cell and
// is accepted when in_valid is high and in_stall is low. The block answers
// on the out_ channel with the cell's four corner vertices and then one or
// two triangles; out_last marks the final result of a cell. A cell with an
// index at or above its count gives one error result instead.
// Pipeline: 34 pipeline stages, the first loaded at the accept, then the
// output hold register carry a cell to its first result. The 32 quotient
// bits of the phase division take eight stages and the seven-step Horner
// series takes 21 stages. The pipeline takes one item per cycle while
// out_stall does not hold it back; the shared result channel then sets the
// sustained rate, as each cell holds it for its five or six results (one
// result for an error cell).
// Stalls: when out_stall holds the result, the pipeline keeps filling its
// empty stages and only raises in_stall when its first stage is occupied
// and cannot move on. Nothing is lost or repeated.
// Reset (rst_n, synchronous, active low) empties the pipeline and sets
// stack_count to 16 and slice_count to 32. The user must write the counts
// at APB byte addresses 0 and 4 only while idle; the block does not enforce it.
module uv_sphere_cell_generator_top #(
  parameter int MAX_DIVISIONS   = 128,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [6:0]         in_stack_index,
  input  logic [6:0]         in_slice_index,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_pos_x,
  output logic signed [15:0] out_pos_y,
  output logic signed [15:0] out_pos_z,
  output logic [15:0]        out_corner_a,
  output logic [15:0]        out_corner_b,
  output logic [15:0]        out_corner_c,
  output logic               out_last,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NSTG = uvs_pkg::NSTG;
  localparam int LANES = uvs_pkg::LANES;
  localparam int DIV_STAGES = uvs_pkg::DIV_STAGES;
  localparam logic [7:0] MAX_CNT = 8'(MAX_DIVISIONS);

  // Configuration registers.
  logic [7:0] stack_count_r;
  logic [7:0] slice_count_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r <= 8'd16;
      slice_count_r <= 8'd32;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        uvs_pkg::REG_STACK_COUNT: stack_count_r <= pwdata[7:0];
        default:                  slice_count_r <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      uvs_pkg::REG_STACK_COUNT: prdata = {24'd0, stack_count_r};
      default:                  prdata = {24'd0, slice_count_r};
    endcase
  end

  // Pipeline control: a stage loads when it is empty or the next one loads.
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;
  logic            hold_v_r;
  logic            hold_rdy;
  logic            out_take;

  assign out_take = out_valid && !out_stall;
  assign hold_rdy = !hold_v_r || (out_take && out_last);
  assign in_stall = !rdy[0];

  always_comb begin
    rdy[NSTG] = hold_rdy;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Per-cell side data, one entry per stage.
  uvs_pkg::side_t side_r [NSTG];

  // Stage 0: range check, vertex base, triangle pattern, first divide step.
  logic [8:0]  rem_r [DIV_STAGES+1][LANES];
  logic [8:0]  den_r [DIV_STAGES+1][LANES];
  logic [31:0] quo_r [DIV_STAGES+1][LANES];

  logic [7:0]     ns;
  logic [7:0]     nl;
  logic [8:0]     num_nxt [LANES];
  logic [8:0]     den_nxt [LANES];
  uvs_pkg::side_t side_nxt;

  always_comb begin
    ns = (stack_count_r > MAX_CNT) ? MAX_CNT : stack_count_r;
    nl = (slice_count_r > MAX_CNT) ? MAX_CNT : slice_count_r;
    side_nxt.err = ({1'b0, in_stack_index} >= ns) || ({1'b0, in_slice_index} >= nl);
    side_nxt.base = (16'(in_stack_index) * 16'(nl) + 16'(in_slice_index)) << 2;
    if (in_stack_index == 7'd0) begin
      side_nxt.tri_kind = uvs_pkg::TRI_FIRST;
    end else if (({1'b0, in_stack_index} + 8'd1) == ns) begin
      side_nxt.tri_kind = uvs_pkg::TRI_LAST;
    end else begin
      side_nxt.tri_kind = uvs_pkg::TRI_MID;
    end
    num_nxt[0] = {2'b00, in_stack_index};
    num_nxt[1] = {2'b00, in_stack_index} + 9'd1;
    num_nxt[2] = {2'b00, in_slice_index};
    num_nxt[3] = {2'b00, in_slice_index} + 9'd1;
    den_nxt[0] = {ns, 1'b0};
    den_nxt[1] = {ns, 1'b0};
    den_nxt[2] = {1'b0, nl};
    den_nxt[3] = {1'b0, nl};
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= (num_nxt[l] >= den_nxt[l]) ? (num_nxt[l] - den_nxt[l]) : num_nxt[l];
        den_r[0][l] <= den_nxt[l];
        quo_r[0][l] <= '0;
      end
    end
  end

  // Side data enters at stage 0 and travels with every stage.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Stages 1..8: restoring division, four quotient bits per stage.
  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    logic [8:0]  rem_nxt [LANES];
    logic [31:0] quo_nxt [LANES];

    always_comb begin
      logic [9:0] r2;
      for (int l = 0; l < LANES; l++) begin
        rem_nxt[l] = rem_r[g-1][l];
        quo_nxt[l] = quo_r[g-1][l];
        for (int s = 0; s < uvs_pkg::DIV_STEPS; s++) begin
          r2 = {rem_nxt[l], 1'b0};
          if (r2 >= {1'b0, den_r[g-1][l]}) begin
            rem_nxt[l] = 9'(r2 - {1'b0, den_r[g-1][l]});
            quo_nxt[l] = {quo_nxt[l][30:0], 1'b1};
          end else begin
            rem_nxt[l] = r2[8:0];
            quo_nxt[l] = {quo_nxt[l][30:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[g][l] <= rem_nxt[l];
          den_r[g][l] <= den_r[g-1][l];
          quo_r[g][l] <= quo_nxt[l];
        end
      end
    end
  end

  // Series state from the octant fold through the last Horner step.
  uvs_pkg::ser_t ser_r [uvs_pkg::ST_A:uvs_pkg::ST_E-1][LANES];

  // Stage A: fold the phase into one octant and scale it to radians.
  uvs_pkg::ser_t fold_nxt [LANES];

  always_comb begin
    logic [31:0] phase;
    logic [29:0] rr;
    logic [60:0] prod;
    for (int l = 0; l < LANES; l++) begin
      phase = quo_r[DIV_STAGES][l];
      fold_nxt[l] = '0;
      fold_nxt[l].quad = phase[31:30];
      fold_nxt[l].swap = phase[29];
      rr = phase[29] ? 30'(31'h4000_0000 - {1'b0, phase[29:0]}) : phase[29:0];
      prod = 61'(rr) * 61'(uvs_pkg::HALF_PI_Q30) + 61'h2000_0000;
      fold_nxt[l].x = prod[59:30];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[uvs_pkg::ST_A]) begin
      ser_r[uvs_pkg::ST_A] <= fold_nxt;
    end
  end

  // Stage B: square of the octant angle; both series start at one.
  uvs_pkg::ser_t sq_nxt [LANES];

  always_comb begin
    logic [59:0] prod;
    for (int l = 0; l < LANES; l++) begin
      sq_nxt[l] = ser_r[uvs_pkg::ST_A][l];
      prod = 60'(ser_r[uvs_pkg::ST_A][l].x) * 60'(ser_r[uvs_pkg::ST_A][l].x);
      sq_nxt[l].x2 = prod[59:30];
      sq_nxt[l].ts = uvs_pkg::Q30_ONE;
      sq_nxt[l].tc = uvs_pkg::Q30_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[uvs_pkg::ST_B]) begin
      ser_r[uvs_pkg::ST_B] <= sq_nxt;
    end
  end

  // Horner steps: multiply by x^2, multiply by the divisor's reciprocal,
  // then correct the quotient by one and subtract from one.
  for (genvar j = 0; j < uvs_pkg::SERIES_STEPS; j++) begin : g_horner
    localparam int S1 = uvs_pkg::ST_H0 + 3 * j;
    localparam logic [7:0]  SDIV = uvs_pkg::sin_div(3'(j));
    localparam logic [7:0]  CDIV = uvs_pkg::cos_div(3'(j));
    localparam logic [31:0] SREC = uvs_pkg::sin_recip(3'(j));
    localparam logic [31:0] CREC = uvs_pkg::cos_recip(3'(j));
    localparam logic [5:0]  SSH  = uvs_pkg::sin_shift(3'(j));
    localparam logic [5:0]  CSH  = uvs_pkg::cos_shift(3'(j));

    uvs_pkg::ser_t mul_nxt [LANES];
    uvs_pkg::ser_t rec_nxt [LANES];
    uvs_pkg::ser_t fix_nxt [LANES];

    always_comb begin
      logic [60:0] ps;
      logic [60:0] pc;
      logic [29:0] qs;
      logic [29:0] qc;
      logic [31:0] rs;
      logic [31:0] rc;
      for (int l = 0; l < LANES; l++) begin
        // Product with x^2.
        mul_nxt[l] = ser_r[S1-1][l];
        ps = 61'(ser_r[S1-1][l].x2) * 61'(ser_r[S1-1][l].ts);
        pc = 61'(ser_r[S1-1][l].x2) * 61'(ser_r[S1-1][l].tc);
        mul_nxt[l].vs = ps[59:30];
        mul_nxt[l].vc = pc[59:30];
        // Reciprocal product.
        rec_nxt[l] = ser_r[S1][l];
        rec_nxt[l].ms = 62'(ser_r[S1][l].vs) * 62'(SREC);
        rec_nxt[l].mc = 62'(ser_r[S1][l].vc) * 62'(CREC);
        // Quotient correction and the new series term.
        fix_nxt[l] = ser_r[S1+1][l];
        qs = 30'(ser_r[S1+1][l].ms >> SSH);
        qc = 30'(ser_r[S1+1][l].mc >> CSH);
        rs = 32'(ser_r[S1+1][l].vs) - 32'(qs) * 32'(SDIV);
        rc = 32'(ser_r[S1+1][l].vc) - 32'(qc) * 32'(CDIV);
        if (rs >= 32'(SDIV)) begin
          qs = qs + 30'd1;
        end
        if (rc >= 32'(CDIV)) begin
          qc = qc + 30'd1;
        end
        fix_nxt[l].ts = uvs_pkg::Q30_ONE - 31'(qs);
        fix_nxt[l].tc = uvs_pkg::Q30_ONE - 31'(qc);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[S1]) begin
        ser_r[S1] <= mul_nxt;
      end
      if (rdy[S1+1]) begin
        ser_r[S1+1] <= rec_nxt;
      end
      if (rdy[S1+2]) begin
        ser_r[S1+2] <= fix_nxt;
      end
    end
  end

  // Stage E: sine from the series, octant swap and quadrant signs.
  uvs_pkg::trig_t trig_r [LANES];
  uvs_pkg::trig_t trig_nxt [LANES];

  always_comb begin
    logic [60:0] prod;
    logic [30:0] s;
    logic [30:0] c;
    for (int l = 0; l < LANES; l++) begin
      prod = 61'(ser_r[uvs_pkg::ST_E-1][l].x) * 61'(ser_r[uvs_pkg::ST_E-1][l].ts);
      if (ser_r[uvs_pkg::ST_E-1][l].swap) begin
        s = ser_r[uvs_pkg::ST_E-1][l].tc;
        c = prod[60:30];
      end else begin
        s = prod[60:30];
        c = ser_r[uvs_pkg::ST_E-1][l].tc;
      end
      case (ser_r[uvs_pkg::ST_E-1][l].quad)
        2'd0: trig_nxt[l] = '{sn_mag: s, sn_neg: 1'b0, cs_mag: c, cs_neg: 1'b0};
        2'd1: trig_nxt[l] = '{sn_mag: c, sn_neg: 1'b0, cs_mag: s, cs_neg: 1'b1};
        2'd2: trig_nxt[l] = '{sn_mag: s, sn_neg: 1'b1, cs_mag: c, cs_neg: 1'b1};
        default: trig_nxt[l] = '{sn_mag: c, sn_neg: 1'b1, cs_mag: s, cs_neg: 1'b0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[uvs_pkg::ST_E]) begin
      trig_r <= trig_nxt;
    end
  end

  // Stage F: corner products. Corner v uses theta lane v/2 and phi lane
  // one for the second and third corners.
  logic [61:0] pxm_r [4];
  logic [61:0] pym_r [4];
  logic        pxn_r [4];
  logic        pyn_r [4];
  logic [61:0] pzm_r [2];
  logic        pzn_r [2];

  always_ff @(posedge clk) begin
    if (rdy[uvs_pkg::ST_F]) begin
      for (int v = 0; v < 4; v++) begin
        pxm_r[v] <= 62'(trig_r[v/2].sn_mag) * 62'(trig_r[2 + ((v == 1 || v == 2) ? 1 : 0)].cs_mag);
        pym_r[v] <= 62'(trig_r[v/2].sn_mag) * 62'(trig_r[2 + ((v == 1 || v == 2) ? 1 : 0)].sn_mag);
        pxn_r[v] <= trig_r[v/2].sn_neg ^ trig_r[2 + ((v == 1 || v == 2) ? 1 : 0)].cs_neg;
        pyn_r[v] <= trig_r[v/2].sn_neg ^ trig_r[2 + ((v == 1 || v == 2) ? 1 : 0)].sn_neg;
      end
      for (int t = 0; t < 2; t++) begin
        pzm_r[t] <= {1'b0, trig_r[t].cs_mag, 30'd0};
        pzn_r[t] <= trig_r[t].cs_neg;
      end
    end
  end

  // Round half away from zero, clamp to one, saturate to 16 bits.
  function automatic logic [15:0] to_field(input logic neg, input logic [61:0] mag);
    logic [61:0] r;
    r = (mag + (62'd1 << (59 - COORD_FRAC_BITS))) >> (60 - COORD_FRAC_BITS);
    if (r > (62'd1 << COORD_FRAC_BITS)) begin
      r = 62'd1 << COORD_FRAC_BITS;
    end
    if (neg) begin
      if (r > 62'd32768) begin
        r = 62'd32768;
      end
      to_field = 16'(62'd0 - r);
    end else begin
      if (r > 62'd32767) begin
        r = 62'd32767;
      end
      to_field = r[15:0];
    end
  endfunction

  // Output hold register with the finished cell.
  logic [15:0]    hx_r [4];
  logic [15:0]    hy_r [4];
  logic [15:0]    hz_r [2];
  uvs_pkg::side_t hside_r;
  logic [2:0]     idx_r;

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      hside_r <= side_r[NSTG-1];
      for (int v = 0; v < 4; v++) begin
        hx_r[v] <= to_field(pxn_r[v], pxm_r[v]);
        hy_r[v] <= to_field(pyn_r[v], pym_r[v]);
      end
      for (int t = 0; t < 2; t++) begin
        hz_r[t] <= to_field(pzn_r[t], pzm_r[t]);
      end
    end
  end

  // Result sequencer: walks the cell's results, one per accepted item.
  logic [2:0] idx_last;

  always_comb begin
    if (hside_r.err) begin
      idx_last = 3'd0;
    end else if (hside_r.tri_kind == uvs_pkg::TRI_MID) begin
      idx_last = 3'd5;
    end else begin
      idx_last = 3'd4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      idx_r    <= 3'd0;
    end else begin
      if (rdy[NSTG]) begin
        hold_v_r <= vld_r[NSTG-1];
      end
      if (out_take) begin
        idx_r <= out_last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  // Result fields of the current item.
  logic [1:0] ca;
  logic [1:0] cb;
  logic [1:0] cc;

  assign out_valid = hold_v_r;
  assign out_last  = (idx_r == idx_last);

  always_comb begin
    case (hside_r.tri_kind)
      uvs_pkg::TRI_FIRST: begin
        ca = 2'd0; cb = 2'd2; cc = 2'd3;
      end
      uvs_pkg::TRI_LAST: begin
        ca = 2'd2; cb = 2'd0; cc = 2'd1;
      end
      default: begin
        if (idx_r[0]) begin
          ca = 2'd1; cb = 2'd2; cc = 2'd3;
        end else begin
          ca = 2'd0; cb = 2'd1; cc = 2'd3;
        end
      end
    endcase

    out_kind     = uvs_pkg::KIND_VERTEX;
    out_pos_x    = '0;
    out_pos_y    = '0;
    out_pos_z    = '0;
    out_corner_a = '0;
    out_corner_b = '0;
    out_corner_c = '0;
    if (hside_r.err) begin
      out_kind = uvs_pkg::KIND_ERROR;
    end else if (!idx_r[2]) begin
      out_pos_x    = hx_r[idx_r[1:0]];
      out_pos_y    = hy_r[idx_r[1:0]];
      out_pos_z    = hz_r[idx_r[1]];
      out_corner_a = hside_r.base + 16'(idx_r[1:0]);
    end else begin
      out_kind     = uvs_pkg::KIND_TRIANGLE;
      out_corner_a = hside_r.base + 16'(ca);
      out_corner_b = hside_r.base + 16'(cb);
      out_corner_c = hside_r.base + 16'(cc);
    end
  end

  // An error cell always ends with its single result.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == uvs_pkg::KIND_ERROR) |-> out_last && (idx_r == 3'd0))
    else $error("error result is not the final one of its cell");

  // The sequencer never runs past the sixth result.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (idx_r <= idx_last))
    else $error("result sequencer beyond the cell's last result");

  // Input is held off only when the first stage is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0] && hold_v_r)
    else $error("input stalled with room in the pipeline");

endmodule
